/* rtl/ehb_pkg.sv */
// ----------------------------------------------------------------------------
// ehb_pkg
// Types, widths and the hash update shared by the bucket hash block.
// ----------------------------------------------------------------------------
package ehb_pkg;

	localparam int BYTE_W    = 8;
	localparam int HASH_W    = 28;
	localparam int SUM_W     = 32;
	localparam int TOP_W     = SUM_W - HASH_W;
	localparam int TS_W      = 16;
	localparam int RADIX_W   = 4;
	localparam int DIV_STEPS = HASH_W / RADIX_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [TS_W-1:0]  TS_RESET  = 16'd1021;
	localparam logic [CNT_W-1:0] CNT_FINAL = CNT_W'(DIV_STEPS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic absorb;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} sts_t;

	function automatic logic [HASH_W-1:0] hash_absorb(
		input logic [HASH_W-1:0] h,
		input logic [BYTE_W-1:0] b
	);
		logic [SUM_W-1:0]  sum;
		logic [TOP_W-1:0]  top;
		logic [HASH_W-1:0] res;
		sum = {h, {TOP_W{1'b0}}} + {{(SUM_W-BYTE_W){1'b0}}, b};
		top = sum[SUM_W-1:HASH_W];
		res = sum[HASH_W-1:0];
		res[2*TOP_W-1:TOP_W] = res[2*TOP_W-1:TOP_W] ^ top;
		return res;
	endfunction

endpackage

/* rtl/ehb_ctrl.sv */
// ----------------------------------------------------------------------------
// ehb_ctrl
// Sequencer: byte intake, remainder iterations and result hand-off.
// ----------------------------------------------------------------------------
module ehb_ctrl
	import ehb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   is_last,
	output logic   in_stall,
	input  logic   out_stall,
	output logic   out_valid,
	output cmd_t   cmd,
	input  sts_t   sts,
	output state_t state
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt    = state_q;
		cmd.absorb   = 1'b0;
		cmd.div_step = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.absorb = in_valid;
				if (in_valid && is_last)
					state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign state     = state_q;

endmodule

/* rtl/ehb_dpath.sv */
// ----------------------------------------------------------------------------
// ehb_dpath
// Running hash, table size register, radix-16 remainder unit, result register.
// ----------------------------------------------------------------------------
module ehb_dpath
	import ehb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic              is_last,
	input  logic              cfg_wr,
	input  logic [TS_W-1:0]   cfg_data,
	output logic [HASH_W-1:0] raw_hash,
	output logic [TS_W-1:0]   bucket
);

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] hash_nxt;
	logic [TS_W-1:0]   table_size_q;
	logic [HASH_W-1:0] fin_hash_q;
	logic [HASH_W-1:0] dvd_q;
	logic [TS_W-1:0]   dvs_q;
	logic [TS_W-1:0]   rem_q;
	logic [TS_W-1:0]   rem_nxt;
	logic [CNT_W-1:0]  cnt_q;
	logic [HASH_W-1:0] raw_hash_q;
	logic [TS_W-1:0]   bucket_q;

	assign hash_nxt = hash_absorb(hash_q, byte_value);

	always_comb begin
		logic [TS_W:0]    t;
		logic [TS_W-1:0]  r;
		r = rem_q;
		for (int i = 0; i < RADIX_W; i++) begin
			t = {r, dvd_q[HASH_W-1-i]};
			if (t >= {1'b0, dvs_q})
				t = t - {1'b0, dvs_q};
			r = t[TS_W-1:0];
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q       <= '0;
			table_size_q <= TS_RESET;
			cnt_q        <= '0;
		end else begin
			if (cfg_wr)
				table_size_q <= cfg_data;
			if (cmd.absorb)
				hash_q <= is_last ? '0 : hash_nxt;
			if (cmd.absorb && is_last)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.absorb && is_last) begin
			fin_hash_q <= hash_nxt;
			dvd_q      <= hash_nxt;
			dvs_q      <= table_size_q;
			rem_q      <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << RADIX_W;
			rem_q <= rem_nxt;
		end
		if (cmd.load_out) begin
			raw_hash_q <= fin_hash_q;
			bucket_q   <= (dvs_q == '0) ? '0 : rem_q;
		end
	end

	assign sts.div_last = (cnt_q == CNT_FINAL);
	assign raw_hash     = raw_hash_q;
	assign bucket       = bucket_q;

endmodule

/* rtl/elf_string_hash_bucket_top.sv */
// ----------------------------------------------------------------------------
// elf_string_hash_bucket_top
// ELF string hash with bucket selection by a configured table size.
// ----------------------------------------------------------------------------
// Key bytes arrive on the input channel (in_valid/in_stall, byte_value,
// is_last), one beat per byte. Each byte that is not the last is absorbed
// without stalling the input and gives no result. The beat flagged is_last
// finishes the hash, which then resets for the next string, and starts the
// remainder unit, which retires four dividend bits per cycle until all 28
// are done; the result register is loaded once the output slot is free.
// A result beat (raw_hash, bucket) then appears on out_valid; in_stall stays
// high from the final byte until the result register is loaded.
// The result register decouples the sides: bytes of the next string, its
// final byte included, are taken while a result is stalled; after that
// final byte in_stall holds until the held result leaves.
// The user writes table_size (cfg_valid/cfg_ready/cfg_data) while no string
// is in flight; the block does not enforce it. A size of zero gives bucket 0.
// Reset clears the running hash, drops any result and sets table_size to
// 1021.
// ----------------------------------------------------------------------------
module elf_string_hash_bucket_top
	import ehb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic              is_last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [HASH_W-1:0] raw_hash,
	output logic [TS_W-1:0]   bucket,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [TS_W-1:0]   cfg_data
);

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	assign cfg_ready = 1'b1;

	ehb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.is_last   (is_last),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.cmd       (cmd),
		.sts       (sts),
		.state     (state)
	);

	ehb_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.byte_value (byte_value),
		.is_last    (is_last),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.raw_hash   (raw_hash),
		.bucket     (bucket)
	);

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && is_last |=> in_stall && state == ST_DIV)
		else $error("final byte did not start the remainder unit");

	a_byte_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !is_last |=> !in_stall)
		else $error("ordinary byte stalled the input");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_valid || !out_stall)
		else $error("result overwrote a stalled beat");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("loaded result not presented");

endmodule
